// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the mapper RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define CMAP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define CMAP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`else

`define CMAP_ASSERT(lbl, clk, rstn, prop, msg)

`define CMAP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- rtl/core/cmap_pkg.sv -----
// ---------------------------------------------------------------------------
// cmap_pkg
// Types, mode codes, Q30 gains and labeling tables of the constellation mapper.
// ---------------------------------------------------------------------------
`default_nettype none

package cmap_pkg;

  localparam int unsigned KW = 30;

  localparam logic [2:0] MODE_BPSK   = 3'd0;
  localparam logic [2:0] MODE_QPSK   = 3'd1;
  localparam logic [2:0] MODE_8PSK   = 3'd2;
  localparam logic [2:0] MODE_16QAM  = 3'd3;
  localparam logic [2:0] MODE_64QAM  = 3'd4;
  localparam logic [2:0] MODE_256QAM = 3'd5;

  localparam logic [KW-1:0] K_INV_SQRT2   = 30'd759250125;
  localparam logic [KW-1:0] K_INV_SQRT10  = 30'd339546978;
  localparam logic [KW-1:0] K_INV_SQRT42  = 30'd165681960;
  localparam logic [KW-1:0] K_INV_SQRT170 = 30'd82352239;
  localparam logic [KW-1:0] K_COS_PI8     = 30'd992008094;
  localparam logic [KW-1:0] K_SIN_PI8     = 30'd410903207;

  // one point component before scaling
  typedef struct packed {
    logic          neg;
    logic [3:0]    level;
    logic [KW-1:0] gain;
  } comp_t;

  localparam logic [3:0] Q64_I [16] = '{
    4'd3, 4'd3, 4'd1, 4'd1, 4'd3, 4'd3, 4'd1, 4'd1,
    4'd5, 4'd5, 4'd7, 4'd7, 4'd5, 4'd5, 4'd7, 4'd7};
  localparam logic [3:0] Q64_Q [16] = '{
    4'd3, 4'd1, 4'd3, 4'd1, 4'd5, 4'd7, 4'd5, 4'd7,
    4'd3, 4'd1, 4'd3, 4'd1, 4'd5, 4'd7, 4'd5, 4'd7};

  localparam logic [3:0] Q256_I [64] = '{
    4'd5,  4'd5,  4'd7,  4'd7,  4'd5,  4'd5,  4'd7,  4'd7,
    4'd3,  4'd3,  4'd1,  4'd1,  4'd3,  4'd3,  4'd1,  4'd1,
    4'd5,  4'd5,  4'd7,  4'd7,  4'd5,  4'd5,  4'd7,  4'd7,
    4'd3,  4'd3,  4'd1,  4'd1,  4'd3,  4'd3,  4'd1,  4'd1,
    4'd11, 4'd11, 4'd9,  4'd9,  4'd11, 4'd11, 4'd9,  4'd9,
    4'd13, 4'd13, 4'd15, 4'd15, 4'd13, 4'd13, 4'd15, 4'd15,
    4'd11, 4'd11, 4'd9,  4'd9,  4'd11, 4'd11, 4'd9,  4'd9,
    4'd13, 4'd13, 4'd15, 4'd15, 4'd13, 4'd13, 4'd15, 4'd15};
  localparam logic [3:0] Q256_Q [64] = '{
    4'd5,  4'd7,  4'd5,  4'd7,  4'd3,  4'd1,  4'd3,  4'd1,
    4'd5,  4'd7,  4'd5,  4'd7,  4'd3,  4'd1,  4'd3,  4'd1,
    4'd11, 4'd9,  4'd11, 4'd9,  4'd13, 4'd15, 4'd13, 4'd15,
    4'd11, 4'd9,  4'd11, 4'd9,  4'd13, 4'd15, 4'd13, 4'd15,
    4'd5,  4'd7,  4'd5,  4'd7,  4'd3,  4'd1,  4'd3,  4'd1,
    4'd5,  4'd7,  4'd5,  4'd7,  4'd3,  4'd1,  4'd3,  4'd1,
    4'd11, 4'd9,  4'd11, 4'd9,  4'd13, 4'd15, 4'd13, 4'd15,
    4'd11, 4'd9,  4'd11, 4'd9,  4'd13, 4'd15, 4'd13, 4'd15};

endpackage

`default_nettype wire

// ----- rtl/core/cmap_intf.sv -----
// ---------------------------------------------------------------------------
// cmap interfaces
// Valid/ready channels for coded bits in and I/Q points out.
// ---------------------------------------------------------------------------
`default_nettype none

interface cmap_bit_if;
  logic valid;
  logic ready;
  logic bit_in;
  logic block_end;

  modport source (output valid, output bit_in, output block_end, input ready);
  modport sink (input valid, input bit_in, input block_end, output ready);
endinterface

interface cmap_sym_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] i_value;
  logic signed [SAMPLE_WIDTH-1:0] q_value;

  modport source (output valid, output i_value, output q_value, input ready);
  modport sink (input valid, input i_value, input q_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cmap_scale.sv -----
// ---------------------------------------------------------------------------
// cmap_scale
// level x Q30 gain, symmetric round half up, sign, saturate to sample width.
// ---------------------------------------------------------------------------
`default_nettype none

module cmap_scale #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned FRAC_BITS    = 14
) (
  input  wire cmap_pkg::comp_t           comp_i,
  output logic signed [SAMPLE_WIDTH-1:0] value_o
);

  localparam int unsigned PW    = cmap_pkg::KW + 5;
  localparam int unsigned SHIFT = cmap_pkg::KW - FRAC_BITS;
  localparam logic [PW-1:0] RND     = PW'(1) << (SHIFT - 1);
  localparam logic [PW-1:0] MAX_POS = (PW'(1) << (SAMPLE_WIDTH - 1)) - PW'(1);
  localparam logic [PW-1:0] MAX_NEG = PW'(1) << (SAMPLE_WIDTH - 1);

  logic [PW-1:0] prod;
  logic [PW-1:0] mag;
  logic [PW-1:0] mag_sat;
  logic [PW-1:0] res;

  always_comb begin
    prod = PW'(comp_i.level) * PW'(comp_i.gain);
    mag  = (prod + RND) >> SHIFT;
    if (!comp_i.neg) begin
      mag_sat = (mag > MAX_POS) ? MAX_POS : mag;
      res     = mag_sat;
    end else begin
      mag_sat = (mag > MAX_NEG) ? MAX_NEG : mag;
      res     = PW'(0) - mag_sat;
    end
  end

  assign value_o = res[SAMPLE_WIDTH-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/constellation_mapper_core.sv -----
// ---------------------------------------------------------------------------
// constellation_mapper_core
// Serial coded bits to BPSK/QPSK/8PSK/16/64/256QAM I/Q points.
// Throughput: one bit transaction per cycle, sustained under no output stall.
// Pipeline: the point that a bit completes passes the label decode register,
//   then the multiply/round/saturate output register.
// Reset: mode returns to BPSK, gathered bits and count clear, pipeline empties.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module constellation_mapper_core #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned FRAC_BITS    = 14
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_wdata_i,
  cmap_bit_if.sink        bits_i,
  cmap_sym_if.source      syms_o
);

  logic [2:0] mode_q;
  logic [7:0] gather_q, gather_d, gather_nx;
  logic [3:0] cnt_q, cnt_d, cnt_nx;
  logic [3:0] need;
  logic       mode_ok;
  logic       emit;
  logic       accept;
  logic       out_adv;
  logic       s1_adv;

  logic            s1_valid_q;
  cmap_pkg::comp_t s1_i_q, s1_q_q;
  cmap_pkg::comp_t dec_i, dec_q;

  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_i_q, out_q_q;
  logic signed [SAMPLE_WIDTH-1:0] scl_i, scl_q;

  assign out_adv      = !out_valid_q || syms_o.ready;
  assign s1_adv       = !s1_valid_q || out_adv;
  assign bits_i.ready = s1_adv;
  assign accept       = bits_i.valid && s1_adv;

  assign gather_nx = {gather_q[6:0], bits_i.bit_in};
  assign cnt_nx    = (cnt_q == 4'd15) ? cnt_q : cnt_q + 4'd1;
  assign mode_ok   = (mode_q <= cmap_pkg::MODE_256QAM);
  assign emit      = mode_ok && (cnt_nx >= need);

  // label decode; label is the low bits of the gathered word
  always_comb begin
    need  = 4'd15;
    dec_i = '0;
    dec_q = '0;
    unique case (mode_q)
      cmap_pkg::MODE_BPSK: begin
        need  = 4'd1;
        dec_i = '{neg: gather_nx[0], level: 4'd1, gain: cmap_pkg::K_INV_SQRT2};
        dec_q = dec_i;
      end
      cmap_pkg::MODE_QPSK: begin
        need  = 4'd2;
        dec_i = '{neg: gather_nx[1], level: 4'd1, gain: cmap_pkg::K_INV_SQRT2};
        dec_q = '{neg: gather_nx[0], level: 4'd1, gain: cmap_pkg::K_INV_SQRT2};
      end
      cmap_pkg::MODE_8PSK: begin
        need  = 4'd3;
        dec_i = '{neg: !gather_nx[2], level: 4'd1,
                  gain: gather_nx[0] ? cmap_pkg::K_COS_PI8 : cmap_pkg::K_SIN_PI8};
        dec_q = '{neg: !gather_nx[1], level: 4'd1,
                  gain: gather_nx[0] ? cmap_pkg::K_SIN_PI8 : cmap_pkg::K_COS_PI8};
      end
      cmap_pkg::MODE_16QAM: begin
        need  = 4'd4;
        dec_i = '{neg: gather_nx[3], level: gather_nx[1] ? 4'd3 : 4'd1,
                  gain: cmap_pkg::K_INV_SQRT10};
        dec_q = '{neg: gather_nx[2], level: gather_nx[0] ? 4'd3 : 4'd1,
                  gain: cmap_pkg::K_INV_SQRT10};
      end
      cmap_pkg::MODE_64QAM: begin
        need  = 4'd6;
        dec_i = '{neg: gather_nx[5], level: cmap_pkg::Q64_I[gather_nx[3:0]],
                  gain: cmap_pkg::K_INV_SQRT42};
        dec_q = '{neg: gather_nx[4], level: cmap_pkg::Q64_Q[gather_nx[3:0]],
                  gain: cmap_pkg::K_INV_SQRT42};
      end
      cmap_pkg::MODE_256QAM: begin
        need  = 4'd8;
        dec_i = '{neg: gather_nx[7], level: cmap_pkg::Q256_I[gather_nx[5:0]],
                  gain: cmap_pkg::K_INV_SQRT170};
        dec_q = '{neg: gather_nx[6], level: cmap_pkg::Q256_Q[gather_nx[5:0]],
                  gain: cmap_pkg::K_INV_SQRT170};
      end
      default: begin
        need  = 4'd15;
      end
    endcase
  end

  always_comb begin
    gather_d = gather_q;
    cnt_d    = cnt_q;
    if (accept) begin
      if (!mode_ok || emit || bits_i.block_end) begin
        gather_d = '0;
        cnt_d    = '0;
      end else begin
        gather_d = gather_nx;
        cnt_d    = cnt_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= cmap_pkg::MODE_BPSK;
      gather_q    <= '0;
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      gather_q <= gather_d;
      cnt_q    <= cnt_d;
      if (s1_adv) begin
        s1_valid_q <= accept && emit;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      s1_i_q <= dec_i;
      s1_q_q <= dec_q;
    end
    if (out_adv && s1_valid_q) begin
      out_i_q <= scl_i;
      out_q_q <= scl_q;
    end
  end

  cmap_scale #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_scale_i (
    .comp_i  (s1_i_q),
    .value_o (scl_i)
  );

  cmap_scale #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_scale_q (
    .comp_i  (s1_q_q),
    .value_o (scl_q)
  );

  assign syms_o.valid   = out_valid_q;
  assign syms_o.i_value = out_i_q;
  assign syms_o.q_value = out_q_q;

  `CMAP_ASSERT(a_end_clears, clk_i, rst_ni, accept && bits_i.block_end |=> cnt_q == 4'd0, "block end left bits gathered")
  `CMAP_ASSERT(a_bad_mode_drop, clk_i, rst_ni, accept && !mode_ok |=> !s1_valid_q && cnt_q == 4'd0, "unused mode produced a symbol")
  `CMAP_ASSERT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !out_adv |=> s1_valid_q && $stable(s1_i_q) && $stable(s1_q_q), "decode stage lost data under stall")
  `CMAP_ASSERT_IMP(a_out_source, clk_i, rst_ni, $rose(out_valid_q), $past(s1_valid_q), "output valid without decoded symbol")

endmodule

`default_nettype wire
